// ===== sv/tcw_pkg.sv =====
// Shared types, constants and helpers of the text console writer.
package tcw_pkg;

   localparam int MAX_COLS   = 80;
   localparam int MAX_ROWS   = 25;
   localparam int TAB_SPACES = 4;
   localparam int CELLS      = MAX_COLS * MAX_ROWS;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int LIN_W  = 12;
   localparam int ADDR_W = $clog2(CELLS + 1);
   localparam int TAB_W  = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int CSR_W  = 8;

   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [7:0]       ATTR_RESET = 8'd15;
   localparam logic [COL_W-1:0] COLS_RESET = COL_W'(MAX_COLS);
   localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(MAX_ROWS);

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_ATTR = 2'd0,
      CSR_COLS = 2'd1,
      CSR_ROWS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      K_CHAR,
      K_NL,
      K_CR,
      K_BS,
      K_TAB,
      K_SET,
      K_CLEAR,
      K_READ
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       ch;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_stat_type;

   function automatic logic [LIN_W-1:0] mul_wr(input logic [COL_W-1:0] w,
                                               input logic [ROW_W-1:0] r);
      return LIN_W'(w) * LIN_W'(r);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] w);
      logic [LIN_W-1:0] s;
      s = LIN_W'(c) + mul_wr(w, r);
      return s[ADDR_W-1:0];
   endfunction

endpackage

// ===== sv/tcw_front.sv =====
// Front end: accepts commands, classifies them and queues them for the back end.
module tcw_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_opcode,
   input  logic [7:0]             req_char_code,
   input  logic [tcw_pkg::COL_W-1:0] req_col_in,
   input  logic [tcw_pkg::ROW_W-1:0] req_row_in,
   input  tcw_pkg::back_stat_type back_stat,
   output logic                   q_valid,
   output tcw_pkg::cmd_type       q_head
);
   import tcw_pkg::*;

   cmd_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push;
   cmd_type           cmd;

   always_comb begin
      cmd.ch  = req_char_code;
      cmd.col = req_col_in;
      cmd.row = req_row_in;
      unique case (req_opcode)
         OP_PUT: begin
            unique case (req_char_code)
               CH_NL:   cmd.kind = K_NL;
               CH_CR:   cmd.kind = K_CR;
               CH_BS:   cmd.kind = K_BS;
               CH_TAB:  cmd.kind = K_TAB;
               default: cmd.kind = K_CHAR;
            endcase
         end
         OP_SET:   cmd.kind = K_SET;
         OP_CLEAR: cmd.kind = K_CLEAR;
         default:  cmd.kind = K_READ;
      endcase
   end

   assign busy    = back_stat.init_busy || (count_ff == (QPTR_W+1)'(QDEPTH));
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = back_stat.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(back_stat.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// ===== sv/tcw_back.sv =====
// Back end: cursor, screen store and the sequencer that carries out each command.
module tcw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  tcw_pkg::cmd_type            q_head,
   output tcw_pkg::back_stat_type      back_stat,
   input  logic [7:0]                  attr,
   input  logic [tcw_pkg::COL_W-1:0]   width,
   input  logic [tcw_pkg::ROW_W-1:0]   height,
   output logic                        rsp_valid,
   output logic [15:0]                 rsp_cell_data,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::LIN_W-1:0]   rsp_cursor_linear,
   output logic                        rsp_status
);
   import tcw_pkg::*;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_PUT,
      S_SCR_RD,
      S_SCR_WR,
      S_FILL,
      S_RD_WAIT,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   kind_type          kind_ff, kind_in;
   logic [7:0]        ch_ff, ch_in;
   logic [COL_W-1:0]  cx_ff, cx_in;
   logic [ROW_W-1:0]  ry_ff, ry_in;
   logic [TAB_W-1:0]  tab_ff, tab_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] scr_end_ff, scr_end_in;
   logic [ADDR_W-1:0] fill_end_ff, fill_end_in;
   logic              ret_put_ff, ret_put_in;
   logic              status_ff, status_in;
   logic [15:0]       cell_ff, cell_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_cell_ff, rsp_cell_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [LIN_W-1:0]  rsp_lin_ff, rsp_lin_in;
   logic              rsp_status_ff, rsp_status_in;

   logic [15:0]       mem [CELLS];
   logic [15:0]       rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [15:0]       mem_wdata;

   logic [ROW_W-1:0]  hm1;
   logic [LIN_W-1:0]  scroll_len;
   logic [15:0]       blank;
   logic              do_nl, nl_ret;
   logic [COL_W-1:0]  bs_col;
   logic [ROW_W-1:0]  bs_row;
   logic              pop;

   assign hm1        = height - 1'b1;
   assign scroll_len = mul_wr(width, hm1);
   assign blank      = {attr, CH_SPACE};

   always_comb begin
      bs_col = col_ff;
      bs_row = row_ff;
      if (col_ff == '0 && row_ff != '0) begin
         bs_row = row_ff - 1'b1;
         bs_col = width;
      end
      if (bs_col != '0) begin
         bs_col = bs_col - 1'b1;
      end
   end

   always_comb begin
      mem_raddr = (state_ff == S_SCR_RD) ? ADDR_W'(ptr_ff + ADDR_W'(width))
                                         : cell_addr(cx_ff, ry_ff, width);
   end

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      kind_in       = kind_ff;
      ch_in         = ch_ff;
      cx_in         = cx_ff;
      ry_in         = ry_ff;
      tab_in        = tab_ff;
      ptr_in        = ptr_ff;
      scr_end_in    = scr_end_ff;
      fill_end_in   = fill_end_ff;
      ret_put_in    = ret_put_ff;
      status_in     = status_ff;
      cell_in       = cell_ff;
      rsp_valid_in  = 1'b0;
      rsp_cell_in   = rsp_cell_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_lin_in    = rsp_lin_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = '0;
      pop           = 1'b0;
      do_nl         = 1'b0;
      nl_ret        = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               pop       = 1'b1;
               kind_in   = q_head.kind;
               ch_in     = q_head.ch;
               cx_in     = q_head.col;
               ry_in     = q_head.row;
               status_in = 1'b0;
               cell_in   = '0;
               tab_in    = '0;
               // pull a cursor left outside a shrunk screen back inside
               if (col_ff > width) col_in = width;
               if (row_ff >= height) row_in = hm1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (kind_ff)
               K_SET: begin
                  if (cx_ff > width || ry_ff >= height) begin
                     status_in = 1'b1;
                  end else begin
                     col_in = cx_ff;
                     row_in = ry_ff;
                  end
                  state_in = S_RESP;
               end
               K_CLEAR: begin
                  col_in      = '0;
                  row_in      = '0;
                  ptr_in      = '0;
                  fill_end_in = ADDR_W'(scroll_len + LIN_W'(width));
                  ret_put_in  = 1'b0;
                  state_in    = S_FILL;
               end
               K_READ: begin
                  if (cx_ff >= width || ry_ff >= height) begin
                     status_in = 1'b1;
                     state_in  = S_RESP;
                  end else begin
                     state_in  = S_RD_WAIT;
                  end
               end
               K_TAB: begin
                  kind_in  = K_CHAR;
                  ch_in    = CH_SPACE;
                  tab_in   = TAB_W'(TAB_SPACES - 1);
                  state_in = S_PUT;
               end
               default: state_in = S_PUT;
            endcase
         end
         S_PUT: begin
            if (col_ff >= width) begin
               do_nl  = 1'b1;
               nl_ret = 1'b1;
            end else begin
               case (kind_ff)
                  K_NL: begin
                     do_nl = 1'b1;
                  end
                  K_CR: begin
                     col_in   = '0;
                     state_in = S_RESP;
                  end
                  K_BS: begin
                     col_in    = bs_col;
                     row_in    = bs_row;
                     mem_we    = 1'b1;
                     mem_waddr = cell_addr(bs_col, bs_row, width);
                     mem_wdata = blank;
                     state_in  = S_RESP;
                  end
                  default: begin
                     mem_we    = 1'b1;
                     mem_waddr = cell_addr(col_ff, row_ff, width);
                     mem_wdata = {attr, ch_ff};
                     col_in    = col_ff + 1'b1;
                     if (tab_ff != '0) begin
                        tab_in = tab_ff - 1'b1;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
               endcase
            end
            if (do_nl) begin
               col_in = '0;
               if ((ROW_W+1)'(row_ff) + 1'b1 < (ROW_W+1)'(height)) begin
                  row_in   = row_ff + 1'b1;
                  state_in = nl_ret ? S_PUT : S_RESP;
               end else begin
                  // scroll: move rows up, then blank the bottom row
                  row_in      = hm1;
                  ptr_in      = '0;
                  scr_end_in  = scroll_len[ADDR_W-1:0];
                  fill_end_in = ADDR_W'(scroll_len + LIN_W'(width));
                  ret_put_in  = nl_ret;
                  state_in    = (scroll_len == '0) ? S_FILL : S_SCR_RD;
               end
            end
         end
         S_SCR_RD: begin
            state_in = S_SCR_WR;
         end
         S_SCR_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            ptr_in    = ptr_ff + 1'b1;
            state_in  = (ptr_ff + 1'b1 == scr_end_ff) ? S_FILL : S_SCR_RD;
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = blank;
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff + 1'b1 == fill_end_ff) begin
               state_in = ret_put_ff ? S_PUT : S_RESP;
            end
         end
         S_RD_WAIT: begin
            cell_in  = rd_data_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_cell_in   = cell_ff;
            rsp_col_in    = col_ff;
            rsp_row_in    = row_ff;
            rsp_lin_in    = LIN_W'(col_ff) + mul_wr(width, row_ff);
            rsp_status_in = status_ff;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      ch_ff         <= ch_in;
      cx_ff         <= cx_in;
      ry_ff         <= ry_in;
      tab_ff        <= tab_in;
      scr_end_ff    <= scr_end_in;
      fill_end_ff   <= fill_end_in;
      ret_put_ff    <= ret_put_in;
      status_ff     <= status_in;
      cell_ff       <= cell_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_lin_ff    <= rsp_lin_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign back_stat = '{pop: pop, init_busy: (state_ff == S_INIT)};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_data     = rsp_cell_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_linear = rsp_lin_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ===== sv/text_console_writer.sv =====
// Top level of the text console writer: control registers, front end and back end.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  command  | start / busy       | req_opcode, req_char_code, req_col_in, req_row_in
//  result   | rsp_valid (strobe) | rsp_cell_data, rsp_cursor_col, rsp_cursor_row,
//           |                    | rsp_cursor_linear, rsp_status
//  control  | csr_we             | csr_index, csr_wdata
//
// A command is taken when start is high and busy low; up to two wait in the queue.
// A command goes from the queue through dispatch and any states of its own (put, read wait,
// scroll or fill) to the response state, which registers the strobe; a wrap adds a put pass.
// A scroll moves w*(h-1) cells up and blanks w cells, a clear blanks w*h, through one store port.
// After reset all 2000 cells of the store are swept to zero with busy held high.
// A result is shown for one cycle only; the receiver cannot hold it off.
module text_console_writer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_opcode,
   input  logic [7:0]                  req_char_code,
   input  logic [tcw_pkg::COL_W-1:0]   req_col_in,
   input  logic [tcw_pkg::ROW_W-1:0]   req_row_in,
   output logic                        rsp_valid,
   output logic [15:0]                 rsp_cell_data,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::LIN_W-1:0]   rsp_cursor_linear,
   output logic                        rsp_status,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [tcw_pkg::CSR_W-1:0]   csr_wdata
);
   import tcw_pkg::*;

   logic [7:0]       attr_ff;
   logic [COL_W-1:0] cols_ff;
   logic [ROW_W-1:0] rows_ff;
   logic [COL_W-1:0] width;
   logic [ROW_W-1:0] height;
   logic             q_valid;
   cmd_type          q_head;
   back_stat_type    back_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ATTR: attr_ff <= csr_wdata[7:0];
            CSR_COLS: cols_ff <= csr_wdata[COL_W-1:0];
            CSR_ROWS: rows_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the geometry to what the store can hold
   always_comb begin
      if (cols_ff == '0) width = COL_W'(1);
      else if (cols_ff > COL_W'(MAX_COLS)) width = COL_W'(MAX_COLS);
      else width = cols_ff;
      if (rows_ff == '0) height = ROW_W'(1);
      else if (rows_ff > ROW_W'(MAX_ROWS)) height = ROW_W'(MAX_ROWS);
      else height = rows_ff;
   end

   tcw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .req_col_in    (req_col_in),
      .req_row_in    (req_row_in),
      .back_stat     (back_stat),
      .q_valid       (q_valid),
      .q_head        (q_head)
   );

   tcw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .back_stat         (back_stat),
      .attr              (attr_ff),
      .width             (width),
      .height            (height),
      .rsp_valid         (rsp_valid),
      .rsp_cell_data     (rsp_cell_data),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_linear (rsp_cursor_linear),
      .rsp_status        (rsp_status)
   );

endmodule

// ===== sv/tcw_checker.sv =====
// Port-level checks of the text console writer and their binding.
module tcw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [15:0]                 rsp_cell_data,
   input logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   input logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   input logic [tcw_pkg::LIN_W-1:0]   rsp_cursor_linear,
   input logic                        rsp_status
);
   import tcw_pkg::*;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy)
      else $error("item taken during store sweep");

   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_cell_data == 16'h0000)
      else $error("cell data on a rejected position");

   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_col <= COL_W'(MAX_COLS) &&
                    rsp_cursor_row < ROW_W'(MAX_ROWS) &&
                    rsp_cursor_linear <= LIN_W'(CELLS))
      else $error("cursor outside the screen");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock             (clock),
   .reset             (reset),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_cell_data     (rsp_cell_data),
   .rsp_cursor_col    (rsp_cursor_col),
   .rsp_cursor_row    (rsp_cursor_row),
   .rsp_cursor_linear (rsp_cursor_linear),
   .rsp_status        (rsp_status)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the text console writer: predicts every result and compares.
`timescale 1ns / 100ps

module testbench;
   import tcw_pkg::*;

   typedef struct {
      logic [1:0]       op;
      logic [7:0]       ch;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      bit               pause;   // hold until all results are in, then write csr
      bit               do_csr;
      logic [1:0]       csr_idx;
      logic [7:0]       csr_val;
   } item_type;

   typedef struct {
      logic [15:0]      cdata;
      logic [COL_W-1:0] ccol;
      logic [ROW_W-1:0] crow;
      logic [LIN_W-1:0] clin;
      logic             stat;
   } result_type;

   logic clock = 0, reset = 1, start = 0, busy;
   logic [1:0] req_opcode = '0;
   logic [7:0] req_char_code = '0;
   logic [COL_W-1:0] req_col_in = '0;
   logic [ROW_W-1:0] req_row_in = '0;
   logic rsp_valid, rsp_status;
   logic [15:0] rsp_cell_data;
   logic [COL_W-1:0] rsp_cursor_col;
   logic [ROW_W-1:0] rsp_cursor_row;
   logic [LIN_W-1:0] rsp_cursor_linear;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   text_console_writer dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // screen model
   logic [15:0] screen [CELLS];
   int unsigned cur_c, cur_r, attr_reg, cols_reg, rows_reg;

   item_type   pending_items[$];
   result_type expected_results[$];
   int errors, mismatches, accepted, results_seen, idle_cycles;
   int n_put, n_set, n_clear, n_read, n_scroll, n_bad;
   bit quiet;

   function automatic int unsigned width_in_use();
      if (cols_reg == 0) return 1;
      return cols_reg > MAX_COLS ? MAX_COLS : cols_reg;
   endfunction

   function automatic int unsigned height_in_use();
      if (rows_reg == 0) return 1;
      return rows_reg > MAX_ROWS ? MAX_ROWS : rows_reg;
   endfunction

   function automatic logic [15:0] blank();
      return {attr_reg[7:0], CH_SPACE};
   endfunction

   function automatic void store_cell(int unsigned c, int unsigned r, logic [15:0] v);
      int unsigned a;
      a = c + width_in_use() * r;
      if (a < CELLS) screen[a] = v;
   endfunction

   function automatic void line_feed();
      int unsigned w, h;
      w = width_in_use();
      h = height_in_use();
      cur_c = 0;
      if (cur_r + 1 < h) begin
         cur_r++;
         return;
      end
      n_scroll++;
      for (int r = 1; r < h; r++)
         for (int c = 0; c < w; c++) screen[c + w * (r - 1)] = screen[c + w * r];
      for (int c = 0; c < w; c++) store_cell(c, h - 1, blank());
      cur_r = h - 1;
   endfunction

   function automatic void type_char(logic [7:0] ch);
      if (cur_c >= width_in_use()) line_feed();
      case (ch)
         CH_NL: line_feed();
         CH_CR: cur_c = 0;
         CH_BS: begin
            if (cur_c == 0 && cur_r >= 1) begin
               cur_r--;
               cur_c = width_in_use();
            end
            if (cur_c >= 1) cur_c--;
            store_cell(cur_c, cur_r, blank());
         end
         CH_TAB: for (int i = 0; i < TAB_SPACES; i++) type_char(CH_SPACE);
         default: begin
            store_cell(cur_c, cur_r, {attr_reg[7:0], ch});
            cur_c++;
         end
      endcase
   endfunction

   function automatic result_type console_step(item_type it);
      result_type res;
      int unsigned w, h;
      w = width_in_use();
      h = height_in_use();
      res = '{default: '0};
      if (cur_c > w) cur_c = w;
      if (cur_r >= h) cur_r = h - 1;
      case (opcode_type'(it.op))
         OP_PUT: begin
            n_put++;
            type_char(it.ch);
         end
         OP_SET: begin
            n_set++;
            if (it.col > w || it.row >= h) res.stat = 1;
            else begin
               cur_c = it.col;
               cur_r = it.row;
            end
         end
         OP_CLEAR: begin
            n_clear++;
            for (int r = 0; r < h; r++)
               for (int c = 0; c < w; c++) store_cell(c, r, blank());
            cur_c = 0;
            cur_r = 0;
         end
         default: begin
            n_read++;
            if (it.col >= w || it.row >= h) res.stat = 1;
            else res.cdata = screen[it.col + w * it.row];
         end
      endcase
      if (res.stat) n_bad++;
      res.ccol = COL_W'(cur_c);
      res.crow = ROW_W'(cur_r);
      res.clin = LIN_W'(cur_c + w * cur_r);
      return res;
   endfunction

   function automatic void add_cmd(opcode_type op, int ch, int c, int r);
      item_type it;
      it = '{default: '0};
      it.op = op;
      it.ch = 8'(ch);
      it.col = COL_W'(c);
      it.row = ROW_W'(r);
      pending_items.push_back(it);
   endfunction

   function automatic void add_csr(csr_index_type idx, int val);
      item_type it;
      it = '{default: '0};
      it.pause = 1;
      it.do_csr = 1;
      it.csr_idx = idx;
      it.csr_val = 8'(val);
      pending_items.push_back(it);
   endfunction

   function automatic void add_put(int ch);
      add_cmd(OP_PUT, ch, $urandom_range(0, 127), $urandom_range(0, 31));
   endfunction

   // busy as seen at the last rising edge
   logic busy_q;

   // driver: items change on the falling edge
   int gap;
   bit draining;
   always @(negedge clock) begin
      if (reset) begin
         start <= 0;
         csr_we <= 0;
      end else if (start && busy_q) begin
         // hold until taken
      end else begin
         bit drive_now, we_now;
         drive_now = 0;
         we_now = 0;
         if (gap > 0) begin
            gap <= gap - 1;
         end else if (pending_items.size() > 0) begin
            if (pending_items[0].pause) begin
               if (expected_results.size() == 0 && !draining) begin
                  draining = 1;
                  gap <= 12;   // let a trailing scroll or clear finish
               end else if (expected_results.size() == 0 && draining && !busy) begin
                  draining = 0;
                  if (pending_items[0].do_csr) begin
                     we_now = 1;
                     csr_index <= pending_items[0].csr_idx;
                     csr_wdata <= pending_items[0].csr_val;
                     case (csr_index_type'(pending_items[0].csr_idx))
                        CSR_ATTR: attr_reg = pending_items[0].csr_val;
                        CSR_COLS: cols_reg = pending_items[0].csr_val[6:0];
                        default:  rows_reg = pending_items[0].csr_val[4:0];
                     endcase
                  end
                  void'(pending_items.pop_front());
               end
            end else begin
               req_opcode <= pending_items[0].op;
               req_char_code <= pending_items[0].ch;
               req_col_in <= pending_items[0].col;
               req_row_in <= pending_items[0].row;
               drive_now = 1;
               if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 12);
            end
         end
         start <= drive_now;
         csr_we <= we_now;
      end
   end

   // sample busy and start at the rising edge for acceptance
   always @(posedge clock) begin
      busy_q <= busy;
      if (!reset && start && !busy) begin
         expected_results.push_back(console_step(pending_items.pop_front()));
         accepted++;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) idle_cycles <= 0;
      else if (rsp_valid) begin
         idle_cycles <= 0;
         results_seen++;
         if (expected_results.size() == 0) begin
            errors++;
            $display("unexpected result at %0t", $realtime);
         end else begin
            result_type e;
            e = expected_results.pop_front();
            if (rsp_cell_data !== e.cdata || rsp_cursor_col !== e.ccol ||
                rsp_cursor_row !== e.crow || rsp_cursor_linear !== e.clin ||
                rsp_status !== e.stat) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp cell %h col %0d row %0d lin %0d st %0d,",
                           e.cdata, e.ccol, e.crow, e.clin, e.stat,
                           " got cell %h col %0d row %0d lin %0d st %0d",
                           rsp_cell_data, rsp_cursor_col, rsp_cursor_row,
                           rsp_cursor_linear, rsp_status);
            end
         end
      end else if (start && !busy) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      // a full-screen scroll or clear plus the start-up sweep fit well under this
      if (idle_cycles > 20000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int cfg_w, cfg_h;
      foreach (screen[i]) screen[i] = '0;
      cur_c = 0;
      cur_r = 0;
      attr_reg = ATTR_RESET;
      cols_reg = COLS_RESET;
      rows_reg = ROWS_RESET;
      gap = 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: every opcode, control characters, wrap, scroll, bounds
      add_cmd(OP_READ, 0, 0, 0);
      add_cmd(OP_READ, 0, 79, 24);
      add_cmd(OP_READ, 0, 80, 0);
      add_cmd(OP_READ, 0, 127, 31);
      add_put(8'hFF);
      add_put(8'h00);
      add_put(CH_TAB);
      add_put(CH_BS);
      add_put(CH_CR);
      add_cmd(OP_SET, 0, 80, 24);
      add_put("A");
      add_cmd(OP_SET, 0, 81, 0);
      add_cmd(OP_SET, 0, 0, 25);
      add_put(CH_NL);
      add_cmd(OP_SET, 0, 0, 1);
      add_put(CH_BS);
      add_cmd(OP_SET, 0, 0, 0);
      add_put(CH_BS);
      add_cmd(OP_READ, 0, 0, 24);
      add_cmd(OP_CLEAR, 0, 0, 0);
      add_cmd(OP_READ, 0, 5, 5);

      // phases of random traffic under varied settings, extremes included
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: begin cfg_w = 8; cfg_h = 3; end
            1: begin cfg_w = 1; cfg_h = 1; end
            2: begin cfg_w = 0; cfg_h = 0; end
            3: begin cfg_w = 127; cfg_h = 31; end
            4: begin cfg_w = 80; cfg_h = 25; end
            default: begin cfg_w = $urandom_range(1, 12); cfg_h = $urandom_range(1, 6); end
         endcase
         add_csr(CSR_ATTR, (ph == 1) ? 0 : (ph == 2) ? 255 : $urandom_range(0, 255));
         add_csr(CSR_COLS, cfg_w | ($urandom_range(0, 1) << 7));
         add_csr(CSR_ROWS, cfg_h | ($urandom_range(0, 7) << 5));
         if (ph == 6) begin
            // shrink with the cursor left beyond the new screen
            add_cmd(OP_SET, 0, cfg_w, cfg_h - 1);
            add_csr(CSR_COLS, 2);
            add_csr(CSR_ROWS, 1);
         end
         for (int i = 0; i < ((ph == 3 || ph == 4) ? 25 : 85); i++) begin
            int k;
            k = $urandom_range(0, 99);
            if (k < 55) add_put($urandom_range(32, 126));
            else if (k < 62) add_put(CH_NL);
            else if (k < 66) add_put(CH_CR);
            else if (k < 71) add_put(CH_BS);
            else if (k < 74) add_put(CH_TAB);
            else if (k < 78) add_put($urandom_range(0, 255));
            else if (k < 84) add_cmd(OP_SET, 0, $urandom_range(0, 14), $urandom_range(0, 7));
            else if (k < 86) add_cmd(OP_SET, 0, $urandom_range(0, 127),
                                     $urandom_range(0, 31));
            else if (k < 87) add_cmd(OP_CLEAR, 0, 0, 0);
            else if (k < 97) add_cmd(OP_READ, 0, $urandom_range(0, 13), $urandom_range(0, 7));
            else add_cmd(OP_READ, 0, $urandom_range(0, 127), $urandom_range(0, 31));
         end
      end
      // set a 10 by 4 screen for a final burst without idling
      add_csr(CSR_COLS, 10);
      add_csr(CSR_ROWS, 4);
      wait (pending_items.size() <= 60);
      quiet = 1;
      for (int i = 0; i < 60; i++)
         if (i % 3 == 0) add_cmd(OP_READ, 0, $urandom_range(0, 9), $urandom_range(0, 3));
         else add_put($urandom_range(0, 255));

      wait (pending_items.size() == 0 && expected_results.size() == 0);
      repeat (50) @(posedge clock);
      $display("Run covered %0d commands: %0d puts, %0d cursor sets, %0d clears, %0d reads.",
               accepted, n_put, n_set, n_clear, n_read);
      $display("Scrolls predicted: %0d, out-of-range requests: %0d.", n_scroll, n_bad);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
